// ----- src/cbm_pkg.sv -----
// package for the chain code boundary marker
// chain code constants, direction helpers and shared types; no dependencies
package cbm_pkg;

	localparam int DIR_W      = 3;
	localparam int CFG_DATA_W = 12;
	localparam int START_W    = 12;

	localparam logic [DIR_W-1:0] DIR_E  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_SE = 3'd1;
	localparam logic [DIR_W-1:0] DIR_S  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_SW = 3'd3;
	localparam logic [DIR_W-1:0] DIR_WE = 3'd4;
	localparam logic [DIR_W-1:0] DIR_NW = 3'd5;
	localparam logic [DIR_W-1:0] DIR_N  = 3'd6;
	localparam logic [DIR_W-1:0] DIR_NE = 3'd7;

	typedef enum logic [1:0] {
		CFG_START_X,
		CFG_START_Y,
		CFG_CLOSING_DIR,
		CFG_CLOSING_DOWN
	} cfg_idx_t;

	typedef struct packed {
		logic [DIR_W-1:0] prev_dir;
		logic             heading_down;
	} hist_t;

	function automatic logic is_down(input logic [DIR_W-1:0] d);
		return (d == DIR_SE) || (d == DIR_S) || (d == DIR_SW);
	endfunction

	function automatic logic is_up(input logic [DIR_W-1:0] d);
		return (d == DIR_NW) || (d == DIR_N) || (d == DIR_NE);
	endfunction

	function automatic logic next_sense(input logic [DIR_W-1:0] d, input logic old);
		logic r;
		r = old;
		if (is_down(d))
			r = 1'b1;
		else if (is_up(d))
			r = 1'b0;
		return r;
	endfunction

	// two bit signed steps: +1, 0, -1
	function automatic logic [1:0] step_dx(input logic [DIR_W-1:0] d);
		logic [1:0] r;
		case (d)
			DIR_E, DIR_SE, DIR_NE:  r = 2'b01;
			DIR_SW, DIR_WE, DIR_NW: r = 2'b11;
			default:                r = 2'b00;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] step_dy(input logic [DIR_W-1:0] d);
		logic [1:0] r;
		case (d)
			DIR_SE, DIR_S, DIR_SW: r = 2'b01;
			DIR_NW, DIR_N, DIR_NE: r = 2'b11;
			default:               r = 2'b00;
		endcase
		return r;
	endfunction

endpackage

// ----- src/cbm_step.sv -----
// one chain code step: seeding, boundary mark decision and next walk state
// depends on cbm_pkg
module cbm_step
	import cbm_pkg::*;
#(
	parameter int CW = 12
) (
	input  logic [DIR_W-1:0] direction,
	input  logic             first,
	input  logic [CW-1:0]    pos_x,
	input  logic [CW-1:0]    pos_y,
	input  hist_t            hist,
	input  logic [CW-1:0]    start_x,
	input  logic [CW-1:0]    start_y,
	input  hist_t            seed,
	output logic [CW-1:0]    point_x,
	output logic [CW-1:0]    point_y,
	output logic             mark,
	output logic [CW-1:0]    next_x,
	output logic [CW-1:0]    next_y,
	output hist_t            next_hist
);

	hist_t      cur;
	logic       spike;
	logic [1:0] dx;
	logic [1:0] dy;

	always_comb begin
		if (first) begin
			point_x = start_x;
			point_y = start_y;
			cur     = seed;
		end else begin
			point_x = pos_x;
			point_y = pos_y;
			cur     = hist;
		end

		spike = (is_up(cur.prev_dir) && is_down(direction)) ||
			(is_down(cur.prev_dir) && is_up(direction));

		mark = 1'b0;
		if (!spike) begin
			if (cur.prev_dir != DIR_E && cur.prev_dir != DIR_WE)
				mark = 1'b1;
			else if ((is_down(direction) && !cur.heading_down) ||
				(is_up(direction) && cur.heading_down))
				mark = 1'b1;
		end

		dx = step_dx(direction);
		dy = step_dy(direction);
		next_x = point_x + {{(CW-2){dx[1]}}, dx};
		next_y = point_y + {{(CW-2){dy[1]}}, dy};

		next_hist.prev_dir     = direction;
		next_hist.heading_down = next_sense(direction, cur.heading_down);
	end

endmodule

// ----- src/chain_code_boundary_marker.sv -----
// top level of the chain code boundary marker: stream ports, config registers, pipeline
// depends on cbm_pkg and cbm_step
//
// channel  | direction | handshake                   | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: direction; tuser: first
// m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: point_x, point_y; tuser: mark
// cfg      | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// one chain code per cycle sustained while the output is not stalled; a code is registered
// on entry in s1, and its result is registered in the result register when s1 advances
// the walk state update is a single increment/decrement per coordinate plus compares
// reset clears config, walk state and both valid flags; no clearing pass
// output stalls hold the result register; the input register refills while the
// result waits, and input ready drops only when both stages are full
module chain_code_boundary_marker
	import cbm_pkg::*;
#(
	parameter int COORD_WIDTH = 12,
	localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // [2:0] direction
	input  logic                   s_axis_tuser,   // [0] first
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,   // point_x, then point_y
	output logic                   m_axis_tuser,   // [0] mark
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = COORD_WIDTH;

	logic [START_W-1:0] start_x_q;
	logic [START_W-1:0] start_y_q;
	logic [DIR_W-1:0]   closing_dir_q;
	logic               closing_down_q;
	hist_t              seed;

	logic [CW-1:0]    pos_x_q;
	logic [CW-1:0]    pos_y_q;
	hist_t            hist_q;

	logic             valid_s1;
	logic [DIR_W-1:0] dir_s1;
	logic             first_s1;

	logic             out_valid_q;
	logic [CW-1:0]    out_x_q;
	logic [CW-1:0]    out_y_q;
	logic             out_mark_q;

	logic             adv;
	logic [CW-1:0]    point_x;
	logic [CW-1:0]    point_y;
	logic             mark;
	logic [CW-1:0]    next_x;
	logic [CW-1:0]    next_y;
	hist_t            next_hist;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q      <= '0;
			start_y_q      <= '0;
			closing_dir_q  <= '0;
			closing_down_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START_X:      start_x_q      <= cfg_data[START_W-1:0];
				CFG_START_Y:      start_y_q      <= cfg_data[START_W-1:0];
				CFG_CLOSING_DIR:  closing_dir_q  <= cfg_data[DIR_W-1:0];
				CFG_CLOSING_DOWN: closing_down_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign seed.prev_dir     = closing_dir_q;
	assign seed.heading_down = next_sense(closing_dir_q, closing_down_q);

	// s1 moves into the result register when that register is free or being drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			dir_s1   <= s_axis_tdata[DIR_W-1:0];
			first_s1 <= s_axis_tuser;
		end
	end

	cbm_step #(
		.CW(CW)
	) u_step (
		.direction (dir_s1),
		.first     (first_s1),
		.pos_x     (pos_x_q),
		.pos_y     (pos_y_q),
		.hist      (hist_q),
		.start_x   (CW'(start_x_q)),
		.start_y   (CW'(start_y_q)),
		.seed      (seed),
		.point_x   (point_x),
		.point_y   (point_y),
		.mark      (mark),
		.next_x    (next_x),
		.next_y    (next_y),
		.next_hist (next_hist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			hist_q  <= '0;
		end else if (adv) begin
			pos_x_q <= next_x;
			pos_y_q <= next_y;
			hist_q  <= next_hist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q    <= point_x;
			out_y_q    <= point_y;
			out_mark_q <= mark;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_y_q, out_x_q});
	assign m_axis_tuser  = out_mark_q;

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid)
		else $error("result register not loaded after transaction moved out of s1");

	a_hist_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> hist_q.prev_dir == $past(dir_s1))
		else $error("previous direction not updated from consumed code");

	a_no_spike_mark: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !first_s1 && is_down(hist_q.prev_dir) && is_up(dir_s1) |=> !m_axis_tuser)
		else $error("spike point marked");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty input register");

endmodule
